### src/sorted_range_floor_lookup_defines.svh
// ---------------------------------------------------------------------------
// sorted_range_floor_lookup_defines.svh
// assertion macros shared by the lookup block's checker
// ---------------------------------------------------------------------------
`ifndef SORTED_RANGE_FLOOR_LOOKUP_DEFINES_SVH
`define SORTED_RANGE_FLOOR_LOOKUP_DEFINES_SVH

// property checked outside of reset
`define SRFL_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("srfl assertion failed");

// property checked at every edge, reset included
`define SRFL_ASSERT_ALWAYS(name, clk, prop) \
   name: assert property (@(posedge clk) prop) \
      else $error("srfl assertion failed");

`endif

### src/srfl_pkg.sv
// ---------------------------------------------------------------------------
// srfl_pkg
// shared types and constants of the sorted range floor lookup
// ---------------------------------------------------------------------------
`default_nettype none

package srfl_pkg;

   localparam int MAX_ENTRIES   = 4096;
   localparam int IDX_W         = $clog2(MAX_ENTRIES);
   localparam int CNT_W         = IDX_W + 1;
   localparam int FIELD_INDEX_W = 12;
   localparam int KEY_W         = 32;
   localparam int ADDR_W        = 32;
   localparam int QUEUE_DEPTH   = 2;
   localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);
   localparam int CSR_ADDR_W    = 3;
   localparam int CSR_DATA_W    = 32;

   localparam logic [ADDR_W-1:0] RECORD_BYTES = ADDR_W'(7);

   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   localparam logic REG_INDEX_BASE = 1'b0;
   localparam logic REG_LAST_INDEX = 1'b1;

   typedef struct packed {
      logic                     is_query;
      logic [IDX_W-1:0]         entry_index;
      logic [KEY_W-1:0]         key;
   } item_type;

   typedef struct packed {
      logic [ADDR_W-1:0]        index_base;
      logic [FIELD_INDEX_W-1:0] last_index;
   } cfg_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_CHECK,
      BK_COMPARE,
      BK_DONE
   } back_state_type;

endpackage

`default_nettype wire

### src/srfl_front.sv
// ---------------------------------------------------------------------------
// srfl_front
// takes request transfers, sorts them into table writes and queries, drops
// writes that fall outside the table
// ---------------------------------------------------------------------------
`default_nettype none

module srfl_front import srfl_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic                     req_kind,
   input  wire logic [FIELD_INDEX_W-1:0] req_entry_index,
   input  wire logic [KEY_W-1:0]         req_key,
   input  wire logic                     q_full,
   output logic                          q_push,
   output item_type                      q_item
);

   logic in_range;
   logic accept;
   logic busy_ff;
   logic busy_in;

   // stall once the queue cannot take another item; busy_ff only holds off
   // the first cycle after reset
   assign req_stall = q_full | busy_ff;
   assign accept    = req_valid & ~req_stall;
   assign in_range  = 32'(req_entry_index) < MAX_ENTRIES;

   always_comb begin
      q_item.is_query    = (req_kind == KIND_QUERY);
      q_item.entry_index = IDX_W'(req_entry_index);
      q_item.key         = req_key;
      // a write beyond the table is taken and forgotten
      q_push             = accept & ((req_kind == KIND_QUERY) | in_range);
      busy_in            = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
      end else begin
         busy_ff <= busy_in;
      end
   end

endmodule

`default_nettype wire

### src/srfl_queue.sv
// ---------------------------------------------------------------------------
// srfl_queue
// short item queue between the front and the search engine
// ---------------------------------------------------------------------------
`default_nettype none

module srfl_queue import srfl_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   input  item_type      push_item,
   output logic          full,
   input  wire logic     pop,
   output logic          head_valid,
   output item_type      head_item
);

   item_type             entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]    wr_ptr_ff;
   logic [QPTR_W-1:0]    wr_ptr_in;
   logic [QPTR_W-1:0]    rd_ptr_ff;
   logic [QPTR_W-1:0]    rd_ptr_in;
   logic [QCNT_W-1:0]    count_ff;
   logic [QCNT_W-1:0]    count_in;
   logic                 do_push;
   logic                 do_pop;

   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_item  = entries_ff[rd_ptr_ff];
   assign do_push    = push & ~full;
   assign do_pop     = pop & head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

### src/srfl_back.sv
// ---------------------------------------------------------------------------
// srfl_back
// start table memory and binary search engine with its result register
// ---------------------------------------------------------------------------
`default_nettype none

module srfl_back import srfl_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  cfg_type                       cfg,
   input  wire logic                     q_valid,
   input  item_type                      q_item,
   output logic                          q_pop,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic [FIELD_INDEX_W-1:0]      rsp_found_index,
   output logic [ADDR_W-1:0]             rsp_record_address,
   output logic                          rsp_exact,
   output logic                          rsp_below_first
);

   logic [KEY_W-1:0]         table_mem [MAX_ENTRIES];
   logic [KEY_W-1:0]         rdata_ff;
   logic                     mem_we;
   logic [IDX_W-1:0]         rd_addr;

   back_state_type           state_ff;
   back_state_type           state_in;
   logic [CNT_W-1:0]         lo_ff;
   logic [CNT_W-1:0]         lo_in;
   logic [IDX_W-1:0]         hi_ff;
   logic [IDX_W-1:0]         hi_in;
   logic [IDX_W-1:0]         mid_ff;
   logic [IDX_W-1:0]         mid_in;
   logic [KEY_W-1:0]         key_ff;
   logic [KEY_W-1:0]         key_in;
   logic [IDX_W-1:0]         found_ff;
   logic [IDX_W-1:0]         found_in;
   logic                     exact_ff;
   logic                     exact_in;
   logic                     below_ff;
   logic                     below_in;
   logic [IDX_W-1:0]         hi_start;
   logic [CNT_W-1:0]         mid_sum;

   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   logic                     rsp_load;
   logic [FIELD_INDEX_W-1:0] rsp_index_ff;
   logic [ADDR_W-1:0]        rsp_addr_ff;
   logic                     rsp_exact_ff;
   logic                     rsp_below_ff;

   // search runs over 0..last_index, held inside the table
   assign hi_start = (32'(cfg.last_index) > MAX_ENTRIES - 1) ? IDX_W'(MAX_ENTRIES - 1)
                                                              : IDX_W'(cfg.last_index);
   assign mid_sum  = lo_ff + CNT_W'(hi_ff);
   assign mid_in   = mid_sum[CNT_W-1:1];
   assign rd_addr  = mid_in;

   always_comb begin
      state_in = state_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      key_in   = key_ff;
      found_in = found_ff;
      exact_in = exact_ff;
      below_in = below_ff;
      q_pop    = 1'b0;
      mem_we   = 1'b0;
      rsp_load = 1'b0;
      unique case (state_ff)
         BK_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               if (q_item.is_query) begin
                  lo_in    = '0;
                  hi_in    = hi_start;
                  key_in   = q_item.key;
                  exact_in = 1'b0;
                  below_in = 1'b0;
                  state_in = BK_CHECK;
               end else begin
                  mem_we = 1'b1;
               end
            end
         end
         BK_CHECK: begin
            // range empty: settle on hi
            if (lo_ff <= CNT_W'(hi_ff)) begin
               state_in = BK_COMPARE;
            end else begin
               found_in = hi_ff;
               state_in = BK_DONE;
            end
         end
         BK_COMPARE: begin
            priority if (rdata_ff == key_ff) begin
               found_in = mid_ff;
               exact_in = 1'b1;
               state_in = BK_DONE;
            end else if (rdata_ff < key_ff) begin
               lo_in    = CNT_W'(mid_ff) + 1'b1;
               state_in = BK_CHECK;
            end else if (mid_ff == '0) begin
               found_in = '0;
               below_in = 1'b1;
               state_in = BK_DONE;
            end else begin
               hi_in    = mid_ff - 1'b1;
               state_in = BK_CHECK;
            end
         end
         BK_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      key_ff   <= key_in;
      found_ff <= found_in;
      exact_ff <= exact_in;
      below_ff <= below_in;
      if (state_ff == BK_CHECK) begin
         mid_ff <= mid_in;
      end
      if (rsp_load) begin
         rsp_index_ff <= FIELD_INDEX_W'(found_ff);
         rsp_addr_ff  <= cfg.index_base + ADDR_W'(found_ff) * RECORD_BYTES;
         rsp_exact_ff <= exact_ff;
         rsp_below_ff <= below_ff;
      end
   end

   // start table with separate write and read addresses, read data registered
   always_ff @(posedge clock) begin
      if (mem_we) begin
         table_mem[q_item.entry_index] <= q_item.key;
      end
      rdata_ff <= table_mem[rd_addr];
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_found_index    = rsp_index_ff;
   assign rsp_record_address = rsp_addr_ff;
   assign rsp_exact          = rsp_exact_ff;
   assign rsp_below_first    = rsp_below_ff;

endmodule

`default_nettype wire

### src/sorted_range_floor_lookup.sv
// ---------------------------------------------------------------------------
// sorted_range_floor_lookup
// Table of ascending range starts with a floor lookup by binary search.
// Write items (kind 0) load one table entry through the search engine. A
// query (kind 1) searches entries 0..last_index and returns the index of
// the entry where it settles, index_base + 7 * index, an exact flag and
// below_first for keys under entry zero. Items go through a two-entry
// queue into the engine one at a time, and the engine takes no new item
// until a query's result is loaded into the result register. A query makes
// at most log2(last_index + 1) + 1 probes, each a check of the range then a
// compare; each probe reads the table memory into a register before the
// compare. Entries must be written before they are searched.
// ---------------------------------------------------------------------------
`default_nettype none

module sorted_range_floor_lookup import srfl_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic                     req_kind,
   input  wire logic [FIELD_INDEX_W-1:0] req_entry_index,
   input  wire logic [KEY_W-1:0]         req_key,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic [FIELD_INDEX_W-1:0]      rsp_found_index,
   output logic [ADDR_W-1:0]             rsp_record_address,
   output logic                          rsp_exact,
   output logic                          rsp_below_first,
   input  wire logic                     csr_psel,
   input  wire logic                     csr_penable,
   input  wire logic                     csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0]    csr_paddr,
   input  wire logic [CSR_DATA_W-1:0]    csr_pwdata,
   output logic [CSR_DATA_W-1:0]         csr_prdata,
   output logic                          csr_pready
);

   cfg_type  cfg_ff;
   cfg_type  cfg_in;
   logic     csr_write;
   logic     reg_sel;
   logic     q_full;
   logic     q_push;
   item_type q_push_item;
   logic     q_pop;
   logic     q_head_valid;
   item_type q_head_item;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;
   assign reg_sel    = csr_paddr[2];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (reg_sel)
            REG_INDEX_BASE: cfg_in.index_base = csr_pwdata;
            REG_LAST_INDEX: cfg_in.last_index = csr_pwdata[FIELD_INDEX_W-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
      unique case (reg_sel)
         REG_INDEX_BASE: csr_prdata = cfg_ff.index_base;
         REG_LAST_INDEX: csr_prdata = CSR_DATA_W'(cfg_ff.last_index);
         default:        csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   srfl_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_kind        (req_kind),
      .req_entry_index (req_entry_index),
      .req_key         (req_key),
      .q_full          (q_full),
      .q_push          (q_push),
      .q_item          (q_push_item)
   );

   srfl_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_item  (q_push_item),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_head_valid),
      .head_item  (q_head_item)
   );

   srfl_back u_back (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg_ff),
      .q_valid            (q_head_valid),
      .q_item             (q_head_item),
      .q_pop              (q_pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_found_index    (rsp_found_index),
      .rsp_record_address (rsp_record_address),
      .rsp_exact          (rsp_exact),
      .rsp_below_first    (rsp_below_first)
   );

endmodule

`default_nettype wire

### src/srfl_checker.sv
// ---------------------------------------------------------------------------
// srfl_checker
// port level checks of the lookup block, bound to the top level
// ---------------------------------------------------------------------------
`default_nettype none

`include "sorted_range_floor_lookup_defines.svh"

module srfl_checker import srfl_pkg::*; (
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     rsp_valid,
   input wire logic                     rsp_stall,
   input wire logic [FIELD_INDEX_W-1:0] rsp_found_index,
   input wire logic [ADDR_W-1:0]        rsp_record_address,
   input wire logic                     rsp_exact,
   input wire logic                     rsp_below_first,
   input wire logic                     csr_pready
);

   // no result left over from before reset
   `SRFL_ASSERT_ALWAYS(a_no_rsp_after_reset, clock, $past(reset) |-> !rsp_valid)

   `SRFL_ASSERT(a_rsp_held, clock, reset, rsp_valid && rsp_stall |=> rsp_valid)

   `SRFL_ASSERT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall |=> $stable(rsp_found_index) && $stable(rsp_record_address) && $stable(rsp_exact) && $stable(rsp_below_first))

   // a key under entry zero settles on index 0 with no match
   `SRFL_ASSERT(a_below_first, clock, reset, rsp_valid && rsp_below_first |-> rsp_found_index == '0 && !rsp_exact)

   `SRFL_ASSERT(a_pready, clock, reset, csr_pready)

endmodule

bind sorted_range_floor_lookup srfl_checker u_srfl_checker (.*);

`default_nettype wire
